/* hw/rtl/btr_pkg.sv */
`timescale 1ns / 1ps

package btr_pkg;

    localparam int COLOR_W     = 15;
    localparam int ROW_ADDR_W  = 13;
    localparam int PAL_W       = 2;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;
    localparam int Q_CW        = 3;

    localparam logic [COLOR_W-1:0] BACKDROP_COLOR = COLOR_W'((29 << 10) | (29 << 5) | 30);

    typedef enum logic [1:0] {
        KIND_TILE_LOAD = 2'd0,
        KIND_PAL_LOAD  = 2'd1,
        KIND_RENDER    = 2'd2,
        KIND_UNUSED    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_TILE_WR = 2'd0,
        OP_PAL_WR  = 2'd1,
        OP_RENDER  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [ROW_ADDR_W-1:0] addr;
        logic [15:0]           data;
        logic [PAL_W-1:0]      pal;
        logic [1:0]            cslot;
        logic                  xflip;
        logic                  blank;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

endpackage

/* hw/rtl/btr_front.sv */
`timescale 1ns / 1ps

module btr_front import btr_pkg::*; #(
    parameter int TILE_COUNT    = 256,
    parameter int PALETTE_COUNT = 4
) (
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_tile_index,
    input  logic [2:0]  i_tile_line,
    input  logic [15:0] i_plane_word,
    input  logic [1:0]  i_palette_slot,
    input  logic [1:0]  i_color_slot,
    input  logic [14:0] i_color_value,
    input  logic [15:0] i_map_word,
    input  logic [2:0]  i_pixel_row,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd
);

    logic [9:0] w_tile;
    logic [2:0] w_pfield;
    logic [2:0] w_srow;
    logic       w_tile_ok;
    logic       w_pal_ok;

    assign w_tile    = i_map_word[9:0];
    assign w_pfield  = i_map_word[12:10];
    assign w_srow    = i_map_word[15] ? ~i_pixel_row : i_pixel_row;
    assign w_tile_ok = {1'b0, w_tile} < 11'(TILE_COUNT);
    assign w_pal_ok  = w_pfield[2] && ({1'b0, w_pfield[1:0]} < 3'(PALETTE_COUNT));

    always_comb begin
        o_cmd       = '0;
        o_cmd_valid = 1'b0;
        unique case (t_kind'(i_kind))
            KIND_TILE_LOAD: begin
                o_cmd.op    = OP_TILE_WR;
                o_cmd.addr  = {2'b00, i_tile_index, i_tile_line};
                o_cmd.data  = i_plane_word;
                o_cmd_valid = {3'b000, i_tile_index} < 11'(TILE_COUNT);
            end
            KIND_PAL_LOAD: begin
                o_cmd.op    = OP_PAL_WR;
                o_cmd.pal   = i_palette_slot;
                o_cmd.cslot = i_color_slot;
                o_cmd.data  = {1'b0, i_color_value};
                o_cmd_valid = {1'b0, i_palette_slot} < 3'(PALETTE_COUNT);
            end
            KIND_RENDER: begin
                o_cmd.op    = OP_RENDER;
                o_cmd.addr  = {w_tile, w_srow};
                o_cmd.pal   = w_pfield[1:0];
                o_cmd.xflip = i_map_word[14];
                o_cmd.blank = !(w_tile_ok && w_pal_ok);
                o_cmd_valid = 1'b1;
            end
            default: begin
                o_cmd_valid = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/btr_queue.sv */
`timescale 1ns / 1ps

module btr_queue import btr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_qs
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_CW-1:0] r_cnt, n_cnt;

    assign o_cmd        = r_mem[r_rp];
    assign o_qs.not_empty = r_cnt != '0;
    assign o_qs.full      = r_cnt == Q_CW'(Q_DEPTH);

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + Q_CW'(i_push) - Q_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

/* hw/rtl/btr_back.sv */
`timescale 1ns / 1ps

module btr_back import btr_pkg::*; #(
    parameter int TILE_COUNT    = 256,
    parameter int PALETTE_COUNT = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  t_q_stat                  i_qs,
    output logic                     o_pop,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic                     o_blank,
    output logic [7:0][COLOR_W-1:0]  o_pix
);

    localparam int ROWS_DEPTH = TILE_COUNT * 8;
    localparam int TAW        = $clog2(ROWS_DEPTH);
    localparam int PAW        = (PALETTE_COUNT > 1) ? $clog2(PALETTE_COUNT) : 1;

    logic [15:0]            r_tile_mem [ROWS_DEPTH];
    logic [4*COLOR_W-1:0]   r_pal_mem  [PALETTE_COUNT];

    logic                   r_m_valid;
    logic [15:0]            r_m_rows;
    logic [4*COLOR_W-1:0]   r_m_colors;
    logic                   r_m_xflip;
    logic                   r_m_blank;

    logic                   r_o_valid;
    logic                   r_o_blank;
    logic [7:0][COLOR_W-1:0] r_o_pix;
    logic [7:0][COLOR_W-1:0] n_o_pix;

    logic w_out_take;
    logic w_m_adv;

    assign w_out_take = !r_o_valid || !i_stall;
    assign w_m_adv    = !r_m_valid || w_out_take;
    assign o_pop      = i_qs.not_empty && w_m_adv;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == OP_TILE_WR) begin
            r_tile_mem[i_cmd.addr[TAW-1:0]] <= i_cmd.data;
        end
        if (w_m_adv) begin
            r_m_rows <= r_tile_mem[i_cmd.addr[TAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == OP_PAL_WR) begin
            r_pal_mem[i_cmd.pal[PAW-1:0]][i_cmd.cslot*COLOR_W +: COLOR_W] <=
                i_cmd.data[COLOR_W-1:0];
        end
        if (w_m_adv) begin
            r_m_colors <= r_pal_mem[i_cmd.pal[PAW-1:0]];
            r_m_xflip  <= i_cmd.xflip;
            r_m_blank  <= i_cmd.blank;
        end
    end

    always_comb begin
        logic [2:0] b;
        logic [1:0] ci;
        n_o_pix = '0;
        for (int x = 0; x < 8; x++) begin
            b  = r_m_xflip ? 3'(x) : 3'(7 - x);
            ci = {r_m_rows[8 + b], r_m_rows[b]};
            if (r_m_blank) begin
                n_o_pix[x] = '0;
            end else if (ci == 2'd0) begin
                n_o_pix[x] = BACKDROP_COLOR;
            end else begin
                n_o_pix[x] = r_m_colors[ci*COLOR_W +: COLOR_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_m_adv) begin
                r_m_valid <= o_pop && i_cmd.op == OP_RENDER;
            end
            if (w_out_take) begin
                r_o_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take && r_m_valid) begin
            r_o_blank <= r_m_blank;
            r_o_pix   <= n_o_pix;
        end
    end

    assign o_valid = r_o_valid;
    assign o_blank = r_o_blank;
    assign o_pix   = r_o_pix;

endmodule

/* hw/rtl/border_tile_row_renderer_unit.sv */
`timescale 1ns / 1ps
// a render passes the queue, the read stage and the output register before o_valid rises
// throughput: one item per cycle while o_stall is low, one tile row read and one palette row read per render
// loads return nothing and take effect for every render accepted after them
// reset clears the queue and the stage valids only
// tile and palette stores are not cleared and hold garbage until loaded

module border_tile_row_renderer_unit import btr_pkg::*; #(
    parameter int TILE_COUNT    = 256,
    parameter int PALETTE_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_tile_index,
    input  logic [2:0]  i_tile_line,
    input  logic [15:0] i_plane_word,
    input  logic [1:0]  i_palette_slot,
    input  logic [1:0]  i_color_slot,
    input  logic [14:0] i_color_value,
    input  logic [15:0] i_map_word,
    input  logic [2:0]  i_pixel_row,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_blank,
    output logic [14:0] o_pixel_0,
    output logic [14:0] o_pixel_1,
    output logic [14:0] o_pixel_2,
    output logic [14:0] o_pixel_3,
    output logic [14:0] o_pixel_4,
    output logic [14:0] o_pixel_5,
    output logic [14:0] o_pixel_6,
    output logic [14:0] o_pixel_7
);

    t_cmd                     w_in_cmd;
    logic                     w_in_cmd_valid;
    t_cmd                     w_head;
    t_q_stat                  w_qs;
    logic                     w_pop;
    logic                     w_push;
    logic [7:0][COLOR_W-1:0]  w_pix;

    btr_front #(
        .TILE_COUNT    (TILE_COUNT),
        .PALETTE_COUNT (PALETTE_COUNT)
    ) u_front (
        .i_kind         (i_kind),
        .i_tile_index   (i_tile_index),
        .i_tile_line    (i_tile_line),
        .i_plane_word   (i_plane_word),
        .i_palette_slot (i_palette_slot),
        .i_color_slot   (i_color_slot),
        .i_color_value  (i_color_value),
        .i_map_word     (i_map_word),
        .i_pixel_row    (i_pixel_row),
        .o_cmd_valid    (w_in_cmd_valid),
        .o_cmd          (w_in_cmd)
    );

    assign o_stall = w_qs.full;
    assign w_push  = i_valid && !w_qs.full && w_in_cmd_valid;

    btr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_in_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head),
        .o_qs    (w_qs)
    );

    btr_back #(
        .TILE_COUNT    (TILE_COUNT),
        .PALETTE_COUNT (PALETTE_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_head),
        .i_qs    (w_qs),
        .o_pop   (w_pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_blank (o_blank),
        .o_pix   (w_pix)
    );

    assign o_pixel_0 = w_pix[0];
    assign o_pixel_1 = w_pix[1];
    assign o_pixel_2 = w_pix[2];
    assign o_pixel_3 = w_pix[3];
    assign o_pixel_4 = w_pix[4];
    assign o_pixel_5 = w_pix[5];
    assign o_pixel_6 = w_pix[6];
    assign o_pixel_7 = w_pix[7];

    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_blank) |-> (o_pixel_0 == '0 && o_pixel_1 == '0 && o_pixel_2 == '0 &&
            o_pixel_3 == '0 && o_pixel_4 == '0 && o_pixel_5 == '0 && o_pixel_6 == '0 &&
            o_pixel_7 == '0))
        else $error("blank row with nonzero pixels");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qs.full |-> w_qs.not_empty)
        else $error("queue full and empty at once");

    a_unused_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_kind == KIND_UNUSED && !w_qs.not_empty)
            |=> !w_qs.not_empty)
        else $error("unused kind entered the queue");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb import btr_pkg::*;;

    localparam int TILES    = 256;
    localparam int PALETTES = 4;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tile_index;
        logic [2:0]  tile_line;
        logic [15:0] plane_word;
        logic [1:0]  palette_slot;
        logic [1:0]  color_slot;
        logic [14:0] color_value;
        logic [15:0] map_word;
        logic [2:0]  pixel_row;
    } t_tile_item;

    typedef struct packed {
        logic             blank;
        logic [7:0][14:0] px;
    } t_row_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_blank;
    logic [14:0] o_pixel_0, o_pixel_1, o_pixel_2, o_pixel_3;
    logic [14:0] o_pixel_4, o_pixel_5, o_pixel_6, o_pixel_7;
    logic [1:0]  i_kind;
    logic [7:0]  i_tile_index;
    logic [2:0]  i_tile_line;
    logic [15:0] i_plane_word;
    logic [1:0]  i_palette_slot;
    logic [1:0]  i_color_slot;
    logic [14:0] i_color_value;
    logic [15:0] i_map_word;
    logic [2:0]  i_pixel_row;

    t_tile_item  cur_item = '0;
    t_tile_item  pending_items[$];
    t_row_result expected_rows[$];

    logic [15:0] tile_mem [0:TILES*8-1];
    logic [14:0] color_mem [0:PALETTES*4-1];
    bit          tile_loaded [0:TILES*8-1];
    bit          color_loaded [0:PALETTES*4-1];

    bit item_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit stall_on = 1'b0;

    int n_queued = 0;
    int n_taken = 0;
    int n_errors = 0;
    int n_checked = 0;
    int n_renders = 0;
    int n_blank = 0;
    int n_tile_loads = 0;
    int n_color_loads = 0;
    int n_unused = 0;

    wire [7:0][14:0] got_px = {o_pixel_7, o_pixel_6, o_pixel_5, o_pixel_4,
                               o_pixel_3, o_pixel_2, o_pixel_1, o_pixel_0};

    assign i_kind         = cur_item.kind;
    assign i_tile_index   = cur_item.tile_index;
    assign i_tile_line    = cur_item.tile_line;
    assign i_plane_word   = cur_item.plane_word;
    assign i_palette_slot = cur_item.palette_slot;
    assign i_color_slot   = cur_item.color_slot;
    assign i_color_value  = cur_item.color_value;
    assign i_map_word     = cur_item.map_word;
    assign i_pixel_row    = cur_item.pixel_row;

    border_tile_row_renderer_unit #(
        .TILE_COUNT    (TILES),
        .PALETTE_COUNT (PALETTES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_tile_index   (i_tile_index),
        .i_tile_line    (i_tile_line),
        .i_plane_word   (i_plane_word),
        .i_palette_slot (i_palette_slot),
        .i_color_slot   (i_color_slot),
        .i_color_value  (i_color_value),
        .i_map_word     (i_map_word),
        .i_pixel_row    (i_pixel_row),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_blank        (o_blank),
        .o_pixel_0      (o_pixel_0),
        .o_pixel_1      (o_pixel_1),
        .o_pixel_2      (o_pixel_2),
        .o_pixel_3      (o_pixel_3),
        .o_pixel_4      (o_pixel_4),
        .o_pixel_5      (o_pixel_5),
        .o_pixel_6      (o_pixel_6),
        .o_pixel_7      (o_pixel_7)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit map_in_range(input logic [15:0] map);
        return int'(map[9:0]) < TILES && int'(map[12:10]) >= 4 &&
               int'(map[12:10]) - 4 < PALETTES;
    endfunction

    function automatic t_row_result render_row_colors(input logic [15:0] map,
                                                      input logic [2:0] row);
        t_row_result r;
        logic [2:0]  srow;
        logic [15:0] planes;
        logic [1:0]  ci;
        int          pal;
        int          b;
        r = '0;
        if (!map_in_range(map)) begin
            r.blank = 1'b1;
            return r;
        end
        pal = int'(map[12:10]) - 4;
        srow = map[15] ? 3'd7 - row : row;
        planes = tile_mem[int'(map[9:0]) * 8 + int'(srow)];
        for (int x = 0; x < 8; x++) begin
            b = map[14] ? x : 7 - x;
            ci = {planes[8 + b], planes[b]};
            r.px[x] = (ci == 2'd0) ? BACKDROP_COLOR : color_mem[pal * 4 + int'(ci)];
        end
        return r;
    endfunction

    task automatic apply_item(input t_tile_item it);
        t_row_result r;
        case (it.kind)
            KIND_TILE_LOAD: begin
                if (int'(it.tile_index) < TILES)
                    tile_mem[int'(it.tile_index) * 8 + int'(it.tile_line)] = it.plane_word;
                n_tile_loads++;
            end
            KIND_PAL_LOAD: begin
                if (int'(it.palette_slot) < PALETTES)
                    color_mem[int'(it.palette_slot) * 4 + int'(it.color_slot)] =
                        it.color_value;
                n_color_loads++;
            end
            KIND_RENDER: begin
                r = render_row_colors(it.map_word, it.pixel_row);
                expected_rows.push_back(r);
                n_renders++;
                if (r.blank) n_blank++;
            end
            default: n_unused++;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        n_errors++;
    endtask

    function automatic t_tile_item rand_item(input t_kind k);
        t_tile_item it;
        it.kind         = k;
        it.tile_index   = 8'($urandom);
        it.tile_line    = 3'($urandom);
        it.plane_word   = 16'($urandom);
        it.palette_slot = 2'($urandom);
        it.color_slot   = 2'($urandom);
        it.color_value  = 15'($urandom);
        it.map_word     = 16'($urandom);
        it.pixel_row    = 3'($urandom);
        return it;
    endfunction

    task automatic queue_item(input t_tile_item it);
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic push_tile_load(input logic [7:0] idx, input logic [2:0] line,
                                  input logic [15:0] planes);
        t_tile_item it;
        it = rand_item(KIND_TILE_LOAD);
        it.tile_index = idx;
        it.tile_line  = line;
        it.plane_word = planes;
        if (int'(idx) < TILES) tile_loaded[int'(idx) * 8 + int'(line)] = 1'b1;
        queue_item(it);
    endtask

    task automatic push_color_load(input logic [1:0] pal, input logic [1:0] slot,
                                   input logic [14:0] color);
        t_tile_item it;
        it = rand_item(KIND_PAL_LOAD);
        it.palette_slot = pal;
        it.color_slot   = slot;
        it.color_value  = color;
        if (int'(pal) < PALETTES) color_loaded[int'(pal) * 4 + int'(slot)] = 1'b1;
        queue_item(it);
    endtask

    // loads whatever the render would read that has never been written
    task automatic push_render(input logic [15:0] map, input logic [2:0] row);
        t_tile_item it;
        logic [2:0] srow;
        int         pal;
        if (map_in_range(map)) begin
            srow = map[15] ? 3'd7 - row : row;
            if (!tile_loaded[int'(map[9:0]) * 8 + int'(srow)])
                push_tile_load(map[7:0], srow, 16'($urandom));
            pal = int'(map[12:10]) - 4;
            for (int c = 1; c < 4; c++)
                if (!color_loaded[pal * 4 + c])
                    push_color_load(2'(pal), 2'(c), 15'($urandom));
        end
        it = rand_item(KIND_RENDER);
        it.map_word  = map;
        it.pixel_row = row;
        queue_item(it);
    endtask

    task automatic build_stimulus();
        logic [15:0] map;
        int          sel;
        int          n_random;
        queue_item(rand_item(KIND_UNUSED));
        push_tile_load(8'd0, 3'd0, 16'h0000);
        push_render(16'h1000, 3'd0);
        push_color_load(2'd3, 2'd3, 15'h7FFF);
        push_tile_load(8'd255, 3'd7, 16'hFFFF);
        push_render(16'h1CFF, 3'd7);
        push_color_load(2'd1, 2'd0, 15'h2AAA);
        push_color_load(2'd1, 2'd1, 15'h0001);
        push_color_load(2'd1, 2'd2, 15'h4000);
        push_color_load(2'd1, 2'd3, 15'h0000);
        push_tile_load(8'd1, 3'd2, 16'h0F35);
        push_render(16'h1401, 3'd2);
        push_render(16'h5401, 3'd2);
        push_render(16'h9401, 3'd5);
        push_render(16'hF401, 3'd5);
        push_render(16'h1100, 3'd3);
        push_render(16'hFFFF, 3'd0);
        push_render(16'h0001, 3'd1);
        push_render(16'h0C01, 3'd6);
        push_render(16'h0000, 3'd7);
        n_random = 0;
        while (n_random < 380) begin
            sel = $urandom_range(99);
            if (sel < 5) begin
                queue_item(rand_item(KIND_UNUSED));
            end else begin
                n_random++;
                if (sel < 28) begin
                    push_tile_load(($urandom_range(1) != 0) ? 8'($urandom_range(15))
                                                           : 8'($urandom),
                                   3'($urandom), 16'($urandom));
                end else if (sel < 42) begin
                    push_color_load(2'($urandom), 2'($urandom), 15'($urandom));
                end else begin
                    map = 16'($urandom);
                    if ($urandom_range(99) < 15) begin
                        if ($urandom_range(1) != 0) map[9:8] = 2'($urandom_range(1, 3));
                        else map[12:10] = 3'($urandom_range(3));
                    end else begin
                        map[9:0] = ($urandom_range(99) < 80) ? 10'($urandom_range(15))
                                                             : 10'($urandom_range(255));
                        map[12:10] = 3'($urandom_range(4, 7));
                    end
                    push_render(map, 3'($urandom));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        item_taken = i_rst_n && i_valid && !o_stall;
        if (item_taken) begin
            apply_item(cur_item);
            n_taken++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || item_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cur_item <= pending_items.pop_front();
                i_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(9) < 4) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall: short stall runs, open runs of varying length
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_on = !stall_on;
            if (stall_on) stall_left = $urandom_range(0, 4);
            else stall_left = ($urandom_range(9) < 2) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end
        i_stall <= stall_on;
    end

    always @(posedge i_clk) begin
        t_row_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rows.size() == 0) begin
                report_mismatch("row with no render pending, blank", int'(o_blank), 0);
            end else begin
                want = expected_rows.pop_front();
                n_checked++;
                if (o_blank !== want.blank)
                    report_mismatch("blank", int'(o_blank), int'(want.blank));
                for (int x = 0; x < 8; x++)
                    if (got_px[x] !== want.px[x])
                        report_mismatch($sformatf("pixel_%0d", x), int'(got_px[x]),
                                        int'(want.px[x]));
            end
        end
    end

    initial begin
        build_stimulus();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (n_taken < n_queued) @(posedge i_clk);
        while (expected_rows.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("sent %0d items: %0d tile loads, %0d color loads, %0d unused kind",
                 n_taken, n_tile_loads, n_color_loads, n_unused);
        $display("checked %0d of %0d rendered rows, %0d of them blank, %0d mismatches",
                 n_checked, n_renders, n_blank, n_errors);
        if (n_errors == 0 && expected_rows.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d rows outstanding", expected_rows.size());
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/btr_pkg.sv
hw/rtl/btr_front.sv
hw/rtl/btr_queue.sv
hw/rtl/btr_back.sv
hw/rtl/border_tile_row_renderer_unit.sv
sim/tb.sv
